[hdl/wpfd_pkg.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame driver package
// Panel geometry, store sizing, command and phase codes, register map and
// small helpers shared by the driver and its frame store.
// ----------------------------------------------------------------------------
package wpfd_pkg;

	// Panel geometry and chain length.
	localparam int PANEL_WIDTH  = 8;
	localparam int PANEL_HEIGHT = 8;
	localparam int LED_TOTAL    = 64;

	// Store address width and a LED counter wide enough to hold LED_TOTAL.
	localparam int ADDR_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
	localparam int LED_W  = $clog2(LED_TOTAL + 1);
	localparam int IDX_W  = 16;

	typedef logic [23:0] colour_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LED_W-1:0] led_t;

	// Command kinds.
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SET  = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;
	localparam logic [1:0] KIND_SHOW = 2'd3;

	// Line phases.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_LATCH = 2'd3;

	// Byte within one LED word, sent in GRB order.
	localparam logic [1:0] PART_GREEN = 2'd0;
	localparam logic [1:0] PART_RED   = 2'd1;
	localparam logic [1:0] PART_BLUE  = 2'd2;

	// Register map, index into the register list.
	localparam int CFG_AW = 5;
	localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [2:0] REG_ONE_LOW   = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [2:0] REG_LATCH     = 3'd4;

	// Register reset values.
	localparam logic [7:0]  RST_ONE_HIGH  = 8'd34;
	localparam logic [7:0]  RST_ONE_LOW   = 8'd14;
	localparam logic [7:0]  RST_ZERO_HIGH = 8'd10;
	localparam logic [7:0]  RST_ZERO_LOW  = 8'd32;
	localparam logic [15:0] RST_LATCH     = 16'd6000;

	// A tick count of zero behaves as one.
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

[hdl/wpfd_if.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame driver channels
// Command request channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface wpfd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] col;
	logic [7:0] row;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, kind, col, row, red, green, blue, input ready);
	modport sink   (input valid, kind, col, row, red, green, blue, output ready);
endinterface

interface wpfd_res_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic ignored;

	modport source (output valid, line_level, busy_res, ignored, input ready);
	modport sink   (input valid, line_level, busy_res, ignored, output ready);
endinterface

[hdl/wpfd_store.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame store
// One GRB word per LED, one write and one registered read per cycle. Per-entry
// valid bits make every entry read as black after reset until written.
// ----------------------------------------------------------------------------
module wpfd_store
	import wpfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  addr_t   wr_addr,
	input  colour_t wr_data,
	input  logic    rd_en,
	input  addr_t   rd_addr,
	output colour_t rd_data
);

	colour_t              mem [LED_TOTAL];
	logic [LED_TOTAL-1:0] vld_q;
	colour_t              rd_word_q;
	logic                 rd_vld_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An entry never written reads as black.
	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

[hdl/ws2812_panel_frame_driver.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame driver
// Frame store with serpentine pixel mapping, fill, and a tick-paced line
// waveform generator for a chain of WS2812 LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one request: tick, set pixel, fill or show. res returns
//   exactly one result per request: line level for the tick, busy flag and
//   a dropped flag (busy, or coordinates outside the panel).
//   A small sequencer handles one request at a time: accept, store read,
//   execute, hand-off. Fill adds a sweep before hand-off that writes the
//   store one entry per cycle. Every tick reads, through the single store
//   read port, the LED word that holds the bit being sent. Results sit in
//   an output register; a new request is accepted while a result waits,
//   and if the receiver stalls the sequencer holds its next result until
//   the register frees. Reset clears the store to black through per-entry
//   valid bits, so no clearing pass is needed, sets the timing registers
//   to their defaults and leaves the line idle. Timing registers must be
//   written over APB only while no request is in flight; the block does
//   not enforce this. A change takes effect at the next phase load.
// ----------------------------------------------------------------------------
module ws2812_panel_frame_driver
	import wpfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	wpfd_cmd_if.sink           cmd,
	wpfd_res_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [CFG_AW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_FILL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]  st_q;

	// Timing registers.
	logic [7:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
	logic [15:0] latch_q;

	// Line state.
	logic [1:0]  phase_q;
	logic [15:0] left_q;
	led_t        led_q;
	logic [1:0]  part_q;
	logic [2:0]  bit_q;

	// Request held while it is worked on.
	logic [1:0]  kind_q;
	logic [7:0]  col_q, row_q;
	colour_t     colour_q;

	// Fill sweep.
	led_t        fill_q;

	// Pending and output results.
	logic        lvl_q, busy_q, drop_q;
	logic        res_valid_q, res_lvl_q, res_busy_q, res_drop_q;

	// Store port.
	logic        wr_en, rd_en;
	addr_t       wr_addr, rd_addr;
	colour_t     wr_data, rd_data;

	// ------------------------------------------------------------------
	// APB register file.
	// ------------------------------------------------------------------
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= RST_ONE_HIGH;
			one_low_q   <= RST_ONE_LOW;
			zero_high_q <= RST_ZERO_HIGH;
			zero_low_q  <= RST_ZERO_LOW;
			latch_q     <= RST_LATCH;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ONE_HIGH:  one_high_q  <= pwdata[7:0];
				REG_ONE_LOW:   one_low_q   <= pwdata[7:0];
				REG_ZERO_HIGH: zero_high_q <= pwdata[7:0];
				REG_ZERO_LOW:  zero_low_q  <= pwdata[7:0];
				REG_LATCH:     latch_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ONE_HIGH:  prdata = {24'd0, one_high_q};
			REG_ONE_LOW:   prdata = {24'd0, one_low_q};
			REG_ZERO_HIGH: prdata = {24'd0, zero_high_q};
			REG_ZERO_LOW:  prdata = {24'd0, zero_low_q};
			REG_LATCH:     prdata = {16'd0, latch_q};
			default:       prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Bit position arithmetic: next position and the one this tick uses.
	// ------------------------------------------------------------------
	logic [15:0] left_dec;
	logic        adv;
	logic        is_show;
	led_t        led_nxt;
	logic [1:0]  part_nxt;
	logic [2:0]  bit_nxt;
	led_t        sel_led;
	logic [1:0]  sel_part;
	logic [2:0]  sel_bit;
	logic [7:0]  sel_byte;
	logic        bit_val;

	assign left_dec = (left_q == 16'd0) ? 16'd0 : left_q - 16'd1;
	assign adv      = (phase_q == PH_LOW) && (left_dec == 16'd0);
	assign is_show  = (kind_q == KIND_SHOW);

	always_comb begin
		led_nxt  = led_q;
		part_nxt = part_q;
		bit_nxt  = bit_q - 3'd1;
		if (bit_q == 3'd0) begin
			bit_nxt = 3'd7;
			if (part_q == PART_BLUE) begin
				part_nxt = PART_GREEN;
				led_nxt  = led_q + led_t'(1);
			end else begin
				part_nxt = part_q + 2'd1;
			end
		end
	end

	// Show starts at the first bit of the chain; a finishing low phase looks
	// ahead to the next bit.
	always_comb begin
		if (is_show) begin
			sel_led  = '0;
			sel_part = PART_GREEN;
			sel_bit  = 3'd7;
		end else if (adv) begin
			sel_led  = led_nxt;
			sel_part = part_nxt;
			sel_bit  = bit_nxt;
		end else begin
			sel_led  = led_q;
			sel_part = part_q;
			sel_bit  = bit_q;
		end
	end

	always_comb begin
		case (sel_part)
			PART_GREEN: sel_byte = rd_data[23:16];
			PART_RED:   sel_byte = rd_data[15:8];
			default:    sel_byte = rd_data[7:0];
		endcase
	end

	assign bit_val = sel_byte[sel_bit];

	// ------------------------------------------------------------------
	// Serpentine mapping for set pixel.
	// ------------------------------------------------------------------
	logic             in_panel;
	logic [7:0]       row_map;
	logic [IDX_W-1:0] pix_idx;
	logic             pix_ok;

	assign in_panel = (col_q < 8'(PANEL_WIDTH)) && (row_q < 8'(PANEL_HEIGHT));
	assign row_map  = col_q[0] ? (8'(PANEL_HEIGHT - 1) - row_q) : row_q;
	assign pix_idx  = IDX_W'(col_q) * IDX_W'(PANEL_HEIGHT) + IDX_W'(row_map);
	assign pix_ok   = in_panel && (pix_idx < IDX_W'(LED_TOTAL));

	// ------------------------------------------------------------------
	// Store access.
	// ------------------------------------------------------------------
	assign rd_en   = (st_q == S_RD);
	assign rd_addr = sel_led[ADDR_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pix_idx[ADDR_W-1:0];
		wr_data = colour_q;
		if (st_q == S_FILL) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[ADDR_W-1:0];
		end else if (st_q == S_EXEC && kind_q == KIND_SET && phase_q == PH_IDLE
				&& pix_ok) begin
			wr_en = 1'b1;
		end
	end

	wpfd_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// Request payload capture.
	// ------------------------------------------------------------------
	assign cmd.ready = (st_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_q   <= cmd.kind;
			col_q    <= cmd.col;
			row_q    <= cmd.row;
			colour_q <= {cmd.green, cmd.red, cmd.blue};
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and line state.
	// ------------------------------------------------------------------
	logic res_free;
	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			phase_q <= PH_IDLE;
			left_q  <= 16'd0;
			led_q   <= '0;
			part_q  <= PART_GREEN;
			bit_q   <= 3'd7;
			fill_q  <= '0;
			lvl_q   <= 1'b0;
			busy_q  <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						st_q <= S_RD;
					end
				end
				S_RD: begin
					st_q <= S_EXEC;
				end
				S_EXEC: begin
					st_q   <= S_DONE;
					lvl_q  <= 1'b0;
					busy_q <= (phase_q != PH_IDLE);
					drop_q <= 1'b0;
					if (kind_q == KIND_TICK) begin
						// Advance the line waveform by one tick.
						case (phase_q)
							PH_HIGH: begin
								lvl_q <= 1'b1;
								if (left_dec == 16'd0) begin
									phase_q <= PH_LOW;
									left_q  <= at_least_one(16'(bit_val ? one_low_q
										: zero_low_q));
								end else begin
									left_q <= left_dec;
								end
							end
							PH_LOW: begin
								if (left_dec == 16'd0) begin
									led_q  <= led_nxt;
									part_q <= part_nxt;
									bit_q  <= bit_nxt;
									if (led_nxt == led_t'(LED_TOTAL)) begin
										phase_q <= PH_LATCH;
										left_q  <= at_least_one(latch_q);
									end else begin
										phase_q <= PH_HIGH;
										left_q  <= at_least_one(16'(bit_val ? one_high_q
											: zero_high_q));
									end
								end else begin
									left_q <= left_dec;
								end
							end
							PH_LATCH: begin
								left_q <= left_dec;
								if (left_dec == 16'd0) begin
									phase_q <= PH_IDLE;
								end
							end
							default: ;
						endcase
					end else if (phase_q != PH_IDLE) begin
						// Commands are dropped while a frame is on the line.
						drop_q <= 1'b1;
					end else begin
						case (kind_q)
							KIND_SET: begin
								drop_q <= !pix_ok;
							end
							KIND_FILL: begin
								st_q   <= S_FILL;
								fill_q <= '0;
							end
							KIND_SHOW: begin
								led_q   <= '0;
								part_q  <= PART_GREEN;
								bit_q   <= 3'd7;
								phase_q <= PH_HIGH;
								busy_q  <= 1'b1;
								left_q  <= at_least_one(16'(bit_val ? one_high_q
									: zero_high_q));
							end
							default: ;
						endcase
					end
				end
				S_FILL: begin
					fill_q <= fill_q + led_t'(1);
					if (fill_q == led_t'(LED_TOTAL - 1)) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (st_q == S_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DONE && res_free) begin
			res_lvl_q  <= lvl_q;
			res_busy_q <= busy_q;
			res_drop_q <= drop_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.line_level = res_lvl_q;
	assign res.busy_res   = res_busy_q;
	assign res.ignored    = res_drop_q;

endmodule

[tb/sv/wpfd_tb_pkg.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame driver line predictor
// Mirrors the frame store, the serpentine pixel mapping, the timing registers
// and the tick-paced bit waveform, and keeps the results that accepted
// requests are still due to produce so that each returned result is checked.
// ----------------------------------------------------------------------------
package wpfd_tb_pkg;
	import wpfd_pkg::*;

	localparam int FRAME_BYTES = LED_TOTAL * 3;

	// One command request as it is presented on the command channel.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} led_request_t;

	// One result as it is returned on the result channel.
	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic ignored;
	} line_result_t;

	class ws2812_line_predictor;
		colour_t      leds[LED_TOTAL];
		int unsigned  byte_pos;
		logic [2:0]   bit_pos;
		logic [1:0]   line_phase;
		int unsigned  ticks_left;
		logic [7:0]   one_high;
		logic [7:0]   one_low;
		logic [7:0]   zero_high;
		logic [7:0]   zero_low;
		logic [15:0]  latch_len;
		line_result_t line_results_due[$];
		int unsigned  results_seen;
		int unsigned  mismatch_count;

		// State after reset: black frame, line idle, default timing.
		function new();
			foreach (leds[i]) leds[i] = '0;
			byte_pos       = 0;
			bit_pos        = 3'd7;
			line_phase     = PH_IDLE;
			ticks_left     = 0;
			one_high       = RST_ONE_HIGH;
			one_low        = RST_ONE_LOW;
			zero_high      = RST_ZERO_HIGH;
			zero_low       = RST_ZERO_LOW;
			latch_len      = RST_LATCH;
			results_seen   = 0;
			mismatch_count = 0;
		endfunction

		// A tick count of zero lasts one tick.
		function int unsigned floor_one(int unsigned v);
			return (v == 0) ? 1 : v;
		endfunction

		// Value of the bit currently on the line, GRB order, MSB first.
		function bit sending_one();
			int unsigned led;
			int unsigned part;
			logic [7:0]  byte_val;
			led  = byte_pos / 3;
			part = byte_pos % 3;
			if (led >= LED_TOTAL) return 1'b0;
			byte_val = 8'(leds[led] >> ((2 - part) * 8));
			return byte_val[bit_pos];
		endfunction

		function void load_high();
			line_phase = PH_HIGH;
			ticks_left = floor_one(sending_one() ? one_high : zero_high);
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_ONE_HIGH:  one_high  = value[7:0];
				REG_ONE_LOW:   one_low   = value[7:0];
				REG_ZERO_HIGH: zero_high = value[7:0];
				REG_ZERO_LOW:  zero_low  = value[7:0];
				REG_LATCH:     latch_len = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] register_value(logic [2:0] idx);
			case (idx)
				REG_ONE_HIGH:  return 32'(one_high);
				REG_ONE_LOW:   return 32'(one_low);
				REG_ZERO_HIGH: return 32'(zero_high);
				REG_ZERO_LOW:  return 32'(zero_low);
				REG_LATCH:     return 32'(latch_len);
				default:       return '0;
			endcase
		endfunction

		function bit is_busy();
			return line_phase != PH_IDLE;
		endfunction

		function int pending();
			return line_results_due.size();
		endfunction

		// Advance the model by one accepted request and queue its result.
		function void take_request(led_request_t req);
			line_result_t due;
			int unsigned  idx;
			due          = '0;
			due.busy_res = (line_phase != PH_IDLE);
			if (req.kind == KIND_TICK) begin
				// A tick spends one tick of the current line phase.
				case (line_phase)
					PH_HIGH: begin
						due.line_level = 1'b1;
						if (ticks_left > 0) ticks_left--;
						if (ticks_left == 0) begin
							line_phase = PH_LOW;
							ticks_left = floor_one(sending_one() ? one_low : zero_low);
						end
					end
					PH_LOW: begin
						if (ticks_left > 0) ticks_left--;
						if (ticks_left == 0) begin
							if (bit_pos == 3'd0) begin
								bit_pos = 3'd7;
								byte_pos++;
							end else begin
								bit_pos--;
							end
							if (byte_pos >= FRAME_BYTES) begin
								line_phase = PH_LATCH;
								ticks_left = floor_one(latch_len);
							end else begin
								load_high();
							end
						end
					end
					PH_LATCH: begin
						if (ticks_left > 0) ticks_left--;
						if (ticks_left == 0) line_phase = PH_IDLE;
					end
					default: ;
				endcase
			end else begin
				// Commands are dropped while a frame or latch is in progress.
				if (line_phase != PH_IDLE) begin
					due.ignored = 1'b1;
				end else if (req.kind == KIND_SET) begin
					if (req.col >= PANEL_WIDTH || req.row >= PANEL_HEIGHT) begin
						due.ignored = 1'b1;
					end else begin
						// Even columns run bottom-up, odd columns top-down.
						idx = req.col * PANEL_HEIGHT +
							(req.col[0] ? PANEL_HEIGHT - 1 - req.row : req.row);
						if (idx >= LED_TOTAL) due.ignored = 1'b1;
						else leds[idx] = {req.green, req.red, req.blue};
					end
				end else if (req.kind == KIND_FILL) begin
					foreach (leds[i]) leds[i] = {req.green, req.red, req.blue};
				end else begin
					byte_pos = 0;
					bit_pos  = 3'd7;
					load_high();
				end
				due.busy_res = (line_phase != PH_IDLE);
			end
			line_results_due.push_back(due);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatch_count++;
		endtask

		// Compare one returned result with the oldest one still due.
		task check_result(line_result_t got);
			line_result_t want;
			results_seen++;
			if (line_results_due.size() == 0) begin
				report_mismatch($sformatf("result %0d (%b) arrived with no request waiting",
					results_seen, got));
				return;
			end
			want = line_results_due.pop_front();
			if (got.line_level !== want.line_level)
				report_mismatch($sformatf("result %0d line_level got %b want %b",
					results_seen, got.line_level, want.line_level));
			if (got.busy_res !== want.busy_res)
				report_mismatch($sformatf("result %0d busy_res got %b want %b",
					results_seen, got.busy_res, want.busy_res));
			if (got.ignored !== want.ignored)
				report_mismatch($sformatf("result %0d ignored got %b want %b",
					results_seen, got.ignored, want.ignored));
		endtask
	endclass

endpackage

[tb/sv/tb_ws2812_panel_frame_driver.sv]
// ----------------------------------------------------------------------------
// WS2812 panel frame driver testbench
// Drives pixel, fill, show and tick requests under several timing settings
// and idling patterns, checks every result against the line predictor, and
// reads back the timing registers after each round of writes.
// ----------------------------------------------------------------------------
module tb_ws2812_panel_frame_driver;
	timeunit 1ns;
	timeprecision 1ps;

	import wpfd_pkg::*;
	import wpfd_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 950;
	localparam int ROUNDS        = 8;
	localparam int REG_SLOTS     = 2 ** (CFG_AW - 2);

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                send_idle_pct;
	int                stall_pct;
	int unsigned       cycle_count;
	ws2812_line_predictor line_model;

	wpfd_cmd_if cmd_ch ();
	wpfd_res_if res_ch ();

	ws2812_panel_frame_driver DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random according to the current idling mode.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Every accepted result is checked against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			line_model.check_result(line_result_t'{res_ch.line_level, res_ch.busy_res,
				res_ch.ignored});
	end

	// Give up after a generous number of cycles.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Present one request, with a random gap first, and wait until it is taken.
	task automatic send_request(led_request_t req);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind  <= req.kind;
		cmd_ch.col   <= req.col;
		cmd_ch.row   <= req.row;
		cmd_ch.red   <= req.red;
		cmd_ch.green <= req.green;
		cmd_ch.blue  <= req.blue;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		line_model.take_request(req);
	endtask

	task automatic send_cmd(logic [1:0] kind, logic [7:0] col, logic [7:0] row,
		logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		send_request(led_request_t'{kind, col, row, red, green, blue});
	endtask

	// Fully random request, kind included.
	function automatic led_request_t any_request();
		led_request_t req;
		req.kind  = 2'($urandom());
		req.col   = 8'($urandom());
		req.row   = 8'($urandom());
		req.red   = 8'($urandom());
		req.green = 8'($urandom());
		req.blue  = 8'($urandom());
		return req;
	endfunction

	// Mostly pixel writes, fills and a show while idle; mostly ticks while busy.
	function automatic led_request_t random_request(bit busy_now);
		led_request_t req;
		int           pick;
		req  = any_request();
		pick = $urandom_range(0, 99);
		if (busy_now) begin
			if (pick < 90) req.kind = KIND_TICK;
			else req.kind = 2'($urandom_range(KIND_SET, KIND_SHOW));
		end else if (pick < 60) begin
			req.kind = KIND_SET;
			if ($urandom_range(0, 7) != 0) begin
				req.col = 8'($urandom_range(0, PANEL_WIDTH - 1));
				req.row = 8'($urandom_range(0, PANEL_HEIGHT - 1));
			end
		end else if (pick < 70) begin
			req.kind = KIND_FILL;
			if ($urandom_range(0, 3) == 0) {req.red, req.green, req.blue} = '0;
		end else if (pick < 82) begin
			req.kind = KIND_SHOW;
		end
		return req;
	endfunction

	// Stop sending and wait until every result due has come back.
	task automatic settle_requests();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (line_model.pending() != 0);
	endtask

	// Setup and access cycle of one APB write; the bus is left selected.
	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		line_model.set_register(idx, value);
	endtask

	// APB read of one register, compared with the predicted value.
	task automatic check_register(logic [2:0] idx);
		logic [31:0] want;
		want    = line_model.register_value(idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want)
			line_model.report_mismatch($sformatf("register %0d read %h want %h",
				idx, prdata, want));
	endtask

	// Write all timing registers and one unused slot, then read the timing registers back.
	task automatic load_timing(logic [7:0] one_hi, logic [7:0] one_lo, logic [7:0] zero_hi,
		logic [7:0] zero_lo, logic [15:0] latch);
		logic [2:0] spare_idx;
		spare_idx = 3'($urandom_range(int'(REG_LATCH) + 1, REG_SLOTS - 1));
		settle_requests();
		write_register(REG_ONE_HIGH, ($urandom() & 32'hFFFF_FF00) | one_hi);
		write_register(REG_ONE_LOW, ($urandom() & 32'hFFFF_FF00) | one_lo);
		write_register(REG_ZERO_HIGH, ($urandom() & 32'hFFFF_FF00) | zero_hi);
		write_register(REG_ZERO_LOW, ($urandom() & 32'hFFFF_FF00) | zero_lo);
		write_register(REG_LATCH, ($urandom() & 32'hFFFF_0000) | latch);
		write_register(spare_idx, $urandom());
		for (int r = REG_ONE_HIGH; r <= REG_LATCH; r++) check_register(3'(r));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		led_request_t req;
		logic [15:0]  drain_latch;

		// Every input starts at a known value, reset held low.
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.kind   = KIND_TICK;
		cmd_ch.col    = '0;
		cmd_ch.row    = '0;
		cmd_ch.red    = '0;
		cmd_ch.green  = '0;
		cmd_ch.blue   = '0;
		res_ch.ready  = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		line_model    = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tick while idle, corners of both column directions,
		// coordinates off the panel, clear and fill, then commands while busy.
		send_cmd(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(KIND_SET, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h00);
		send_cmd(KIND_SET, 8'd7, 8'd7, 8'h00, 8'hFF, 8'h00);
		send_cmd(KIND_SET, 8'd1, 8'd0, 8'h00, 8'h00, 8'hFF);
		send_cmd(KIND_SET, 8'd1, 8'd7, 8'h55, 8'hAA, 8'h0F);
		send_cmd(KIND_SET, 8'd8, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(KIND_SET, 8'd0, 8'd8, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(KIND_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(KIND_FILL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(KIND_FILL, 8'd0, 8'd0, 8'hA5, 8'h5A, 8'hC3);
		send_cmd(KIND_SET, 8'd0, 8'd0, 8'h00, 8'h80, 8'h01);
		send_cmd(KIND_SET, 8'd7, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(KIND_SHOW, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(KIND_SET, 8'd2, 8'd2, 8'h12, 8'h34, 8'h56);
		send_cmd(KIND_FILL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		send_cmd(KIND_SHOW, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
		repeat (8) send_cmd(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		// Random rounds, each under its own timing and idling pattern.
		for (int p = 0; p < ROUNDS; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 69; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 69; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			case (p)
				0: load_timing(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
				1: load_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
				2: load_timing(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
				3: load_timing(RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH, RST_ZERO_LOW,
					RST_LATCH);
				default: load_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
					16'($urandom_range(1, 65535)));
			endcase
			for (int n = 0; n < RANDOM_ITEMS / ROUNDS; n++)
				send_request(random_request(line_model.is_busy()));

			// Short timing, one and zero bits of different length, so that the
			// rest of the frame and its latch run out and the data shows.
			drain_latch = (p == 3) ? 16'($urandom_range(300, 500)) :
				16'($urandom_range(0, 3));
			load_timing(8'd2, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
				8'($urandom_range(1, 2)), drain_latch);
			while (line_model.is_busy()) begin
				req      = any_request();
				req.kind = KIND_TICK;
				send_request(req);
			end
		end

		// Let the last results arrive, then a few quiet cycles.
		settle_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (line_model.mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
hdl/wpfd_pkg.sv
hdl/wpfd_if.sv
hdl/wpfd_store.sv
hdl/ws2812_panel_frame_driver.sv
tb/sv/wpfd_tb_pkg.sv
tb/sv/tb_ws2812_panel_frame_driver.sv
